// ===== hw/rtl/sbh_pkg.sv =====
`default_nettype none
package sbh_pkg;

    localparam int EXT_BITS = 16;
    localparam int N_AXES   = 3;

    typedef struct packed {
        logic use_start;
        logic use_end;
    } t_sel;

endpackage
`default_nettype wire

// ===== hw/rtl/sbh_dot.sv =====
`default_nettype none
module sbh_dot
    import sbh_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic [9*COORD_BITS+3*EXT_BITS-1:0]     i_data,
    output logic                                        o_valid,
    output logic [((2*(COORD_BITS+1)+2 > 64) ? 64 : 2*(COORD_BITS+1)+2)-1:0] o_c1,
    output logic [((2*(COORD_BITS+1)+2 > 64) ? 64 : 2*(COORD_BITS+1)+2)-1:0] o_c2,
    output logic [6*COORD_BITS+3*(COORD_BITS+1)+3*EXT_BITS-1:0] o_side
);

    localparam int C   = COORD_BITS;
    localparam int D   = C + 1;
    localparam int PW  = 2 * D;
    localparam int FW  = PW + 2;
    localparam int SW  = (FW > 64) ? 64 : FW;
    localparam int EB  = 3 * EXT_BITS;

    // stage 1: deltas
    logic               r1_valid;
    logic signed [C-1:0] r1_s [N_AXES];
    logic signed [C-1:0] r1_c [N_AXES];
    logic signed [D-1:0] r1_v [N_AXES];
    logic signed [D-1:0] r1_w [N_AXES];
    logic [EB-1:0]       r1_ext;

    // stage 2: products
    logic                 r2_valid;
    logic signed [PW-1:0] r2_pw [N_AXES];
    logic signed [PW-1:0] r2_pv [N_AXES];
    logic [6*C+3*D+EB-1:0] r2_side;

    // stage 3: sums
    logic                  r3_valid;
    logic [SW-1:0]         r3_c1;
    logic [SW-1:0]         r3_c2;
    logic [6*C+3*D+EB-1:0] r3_side;

    logic signed [FW-1:0] n_c1;
    logic signed [FW-1:0] n_c2;
    logic [6*C+3*D+EB-1:0] n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_AXES; i++) begin
                r1_s[i] <= $signed(i_data[i*C +: C]);
                r1_c[i] <= $signed(i_data[(6+i)*C +: C]);
                r1_v[i] <= D'($signed(i_data[(3+i)*C +: C])) - D'($signed(i_data[i*C +: C]));
                r1_w[i] <= D'($signed(i_data[(6+i)*C +: C])) - D'($signed(i_data[i*C +: C]));
                r2_pw[i] <= PW'(r1_w[i]) * PW'(r1_v[i]);
                r2_pv[i] <= PW'(r1_v[i]) * PW'(r1_v[i]);
            end
            r1_ext  <= i_data[9*C +: EB];
            r2_side <= n_side;
            r3_c1   <= n_c1[SW-1:0];
            r3_c2   <= n_c2[SW-1:0];
            r3_side <= r2_side;
        end
    end

    always_comb begin
        n_side = {r1_ext,
                  r1_c[2], r1_c[1], r1_c[0],
                  r1_v[2], r1_v[1], r1_v[0],
                  r1_s[2], r1_s[1], r1_s[0]};
        n_c1 = FW'(r2_pw[0]) + FW'(r2_pw[1]) + FW'(r2_pw[2]);
        n_c2 = FW'(r2_pv[0]) + FW'(r2_pv[1]) + FW'(r2_pv[2]);
    end

    assign o_valid = r3_valid;
    assign o_c1    = r3_c1;
    assign o_c2    = r3_c2;
    assign o_side  = r3_side;

endmodule
`default_nettype wire

// ===== hw/rtl/sbh_div.sv =====
`default_nettype none
module sbh_div
    import sbh_pkg::*;
#(
    parameter int SUM_BITS   = 52,
    parameter int RATIO_BITS = 16,
    parameter int SIDE_BITS  = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [SUM_BITS-1:0]   i_c1,
    input  wire logic [SUM_BITS-1:0]   i_c2,
    input  wire logic [SIDE_BITS-1:0]  i_side,
    output logic                       o_valid,
    output t_sel                       o_sel,
    output logic [RATIO_BITS-1:0]      o_q,
    output logic [SIDE_BITS-1:0]       o_side
);

    localparam int RW = SUM_BITS + 1;
    localparam int R  = RATIO_BITS;

    logic                 r_valid [R];
    t_sel                 r_sel   [R];
    logic [RW-1:0]        r_rem   [R];
    logic [SUM_BITS-1:0]  r_den   [R];
    logic [R-1:0]         r_q     [R];
    logic [SIDE_BITS-1:0] r_side  [R];

    t_sel n_sel0;

    always_comb begin
        n_sel0.use_start = i_c1[SUM_BITS-1] || (i_c1 == '0);
        n_sel0.use_end   = (i_c2 <= i_c1);
    end

    for (genvar k = 0; k < R; k++) begin : g_step
        logic                 a_valid;
        t_sel                 a_sel;
        logic [RW-1:0]        a_rem;
        logic [SUM_BITS-1:0]  a_den;
        logic [R-1:0]         a_q;
        logic [SIDE_BITS-1:0] a_side;
        logic [RW-1:0]        n_sh;
        logic                 n_ge;

        if (k == 0) begin : g_first
            assign a_valid = i_valid;
            assign a_sel   = n_sel0;
            assign a_rem   = {1'b0, i_c1};
            assign a_den   = i_c2;
            assign a_q     = '0;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_valid = r_valid[k-1];
            assign a_sel   = r_sel[k-1];
            assign a_rem   = r_rem[k-1];
            assign a_den   = r_den[k-1];
            assign a_q     = r_q[k-1];
            assign a_side  = r_side[k-1];
        end

        assign n_sh = {a_rem[RW-2:0], 1'b0};
        assign n_ge = n_sh >= {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sel[k]  <= a_sel;
                r_rem[k]  <= n_ge ? (n_sh - {1'b0, a_den}) : n_sh;
                r_den[k]  <= a_den;
                r_q[k]    <= {a_q[R-2:0], n_ge};
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_valid[R-1];
    assign o_sel   = r_sel[R-1];
    assign o_q     = r_q[R-1];
    assign o_side  = r_side[R-1];

endmodule
`default_nettype wire

// ===== hw/rtl/sbh_point.sv =====
`default_nettype none
module sbh_point
    import sbh_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int RATIO_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire t_sel                  i_sel,
    input  wire logic [RATIO_BITS-1:0] i_q,
    input  wire logic [6*COORD_BITS+3*(COORD_BITS+1)+3*EXT_BITS-1:0] i_side,
    output logic                       o_valid,
    output logic                       o_hit
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int R  = RATIO_BITS;
    localparam int MW = D + R + 1;
    localparam int W  = C + 3;
    localparam int SO = 0;
    localparam int VO = 3 * C;
    localparam int CO = 3 * C + 3 * D;
    localparam int EO = 6 * C + 3 * D;

    // stage a: scaled offsets
    logic                 ra_valid;
    t_sel                 ra_sel;
    logic signed [D:0]    ra_off [N_AXES];
    logic [EO+3*EXT_BITS-1:0] ra_side;

    // stage b: point and box bounds
    logic                 rb_valid;
    logic signed [W-1:0]  rb_p  [N_AXES];
    logic signed [W-1:0]  rb_lo [N_AXES];
    logic signed [W-1:0]  rb_hi [N_AXES];

    // stage c: result
    logic                 rc_valid;
    logic                 rc_hit;

    logic signed [MW-1:0] n_prod [N_AXES];
    logic signed [W-1:0]  n_s    [N_AXES];
    logic signed [W-1:0]  n_v    [N_AXES];
    logic signed [W-1:0]  n_c    [N_AXES];
    logic signed [W-1:0]  n_up   [N_AXES];
    logic signed [W-1:0]  n_dn   [N_AXES];
    logic [N_AXES-1:0]    n_in;

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            n_prod[i] = MW'($signed(i_side[VO+i*D +: D])) * $signed({1'b0, i_q});
            n_s[i] = W'($signed(ra_side[SO+i*C +: C]));
            n_v[i] = W'($signed(ra_side[VO+i*D +: D]));
            n_c[i] = W'($signed(ra_side[CO+i*C +: C]));
        end
        n_up[0] = W'(ra_side[EO +: EXT_BITS]);
        n_dn[0] = W'(ra_side[EO +: EXT_BITS]);
        n_up[1] = n_up[0];
        n_dn[1] = n_dn[0];
        n_up[2] = W'(ra_side[EO+EXT_BITS +: EXT_BITS]);
        n_dn[2] = W'(ra_side[EO+2*EXT_BITS +: EXT_BITS]);
        for (int i = 0; i < N_AXES; i++) begin
            n_in[i] = (rb_p[i] <= rb_hi[i]) && (rb_p[i] >= rb_lo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
            rb_valid <= 1'b0;
            rc_valid <= 1'b0;
        end else if (i_en) begin
            ra_valid <= i_valid;
            rb_valid <= ra_valid;
            rc_valid <= rb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_sel  <= i_sel;
            ra_side <= i_side;
            for (int i = 0; i < N_AXES; i++) begin
                ra_off[i] <= n_prod[i][R +: D+1];
                case ({ra_sel.use_start, ra_sel.use_end})
                    2'b10, 2'b11: begin
                        rb_p[i] <= n_s[i];
                    end
                    2'b01: begin
                        rb_p[i] <= n_s[i] + n_v[i];
                    end
                    default: begin
                        rb_p[i] <= n_s[i] + W'(ra_off[i]);
                    end
                endcase
                rb_lo[i] <= n_c[i] - n_dn[i];
                rb_hi[i] <= n_c[i] + n_up[i];
            end
            rc_hit <= &n_in;
        end
    end

    assign o_valid = rc_valid;
    assign o_hit   = rc_hit;

endmodule
`default_nettype wire

// ===== hw/rtl/segment_box_hit_test.sv =====
// segment versus box hit test
// slave stream: one transaction per test; tdata carries the segment start and
// end points, the entity centre and the box extents
// master stream: one transaction per test; tdata bit 0 is the hit flag
// the pipeline is three dot product stages, one restoring division step per
// ratio bit, and three stages for the point and the box compare
// throughput: one test per cycle while the receiver takes results
// reset clears every valid bit; the pipeline is empty afterwards
// when the receiver stalls with a result waiting, the whole pipeline holds
// and o_s_axis_tready drops; nothing is lost or repeated
// tests may enter back to back; results leave in order of entry
`default_nettype none
module segment_box_hit_test
    import sbh_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int RATIO_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    // center_x, center_y, center_z, half_width, extent_above, extent_below
    input  wire logic [((9*COORD_BITS+3*EXT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // hit
    output logic [7:0] o_m_axis_tdata
);

    localparam int C      = COORD_BITS;
    localparam int D      = C + 1;
    localparam int IN_W   = 9 * C + 3 * EXT_BITS;
    localparam int FW     = 2 * D + 2;
    localparam int SW     = (FW > 64) ? 64 : FW;
    localparam int SIDE_W = 6 * C + 3 * D + 3 * EXT_BITS;

    logic              en;
    logic              dot_valid;
    logic [SW-1:0]     dot_c1;
    logic [SW-1:0]     dot_c2;
    logic [SIDE_W-1:0] dot_side;
    logic              div_valid;
    t_sel              div_sel;
    logic [RATIO_BITS-1:0] div_q;
    logic [SIDE_W-1:0] div_side;
    logic              pt_valid;
    logic              pt_hit;

    assign en = !pt_valid || i_m_axis_tready;

    sbh_dot #(.COORD_BITS(C)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata[IN_W-1:0]),
        .o_valid (dot_valid),
        .o_c1    (dot_c1),
        .o_c2    (dot_c2),
        .o_side  (dot_side)
    );

    sbh_div #(.SUM_BITS(SW), .RATIO_BITS(RATIO_BITS), .SIDE_BITS(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dot_valid),
        .i_c1    (dot_c1),
        .i_c2    (dot_c2),
        .i_side  (dot_side),
        .o_valid (div_valid),
        .o_sel   (div_sel),
        .o_q     (div_q),
        .o_side  (div_side)
    );

    sbh_point #(.COORD_BITS(C), .RATIO_BITS(RATIO_BITS)) u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_sel   (div_sel),
        .i_q     (div_q),
        .i_side  (div_side),
        .o_valid (pt_valid),
        .o_hit   (pt_hit)
    );

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = pt_valid;
    assign o_m_axis_tdata  = {7'd0, pt_hit};

endmodule
`default_nettype wire

// ===== hw/rtl/sbh_checker.sv =====
`default_nettype none
module sbh_checker
    import sbh_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_axis_tvalid,
    input wire logic o_s_axis_tready,
    input wire logic [((9*COORD_BITS+3*EXT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata
);

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("ready does not follow output state");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:1] == 7'd0))
        else $error("padding bits set");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && !o_s_axis_tready) |=>
            (i_s_axis_tvalid && $stable(i_s_axis_tdata)))
        else $error("waiting input transaction changed");

endmodule

bind segment_box_hit_test sbh_checker #(.COORD_BITS(COORD_BITS)) u_sbh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbh_pkg::*;

    localparam int CB = 24;
    localparam int RB = 16;
    localparam int DW = ((9*CB+3*EXT_BITS+7)/8)*8;
    localparam int LIMIT = 400000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [DW-1:0] i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [7:0]    o_m_axis_tdata;

    segment_box_hit_test #(.COORD_BITS(CB), .RATIO_BITS(RB)) dut (.*);

    always #1 i_clk = ~i_clk;

    logic [DW-1:0] pending_tests[$];
    logic          hits_due[$];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            phase = 0;
    bit            hold_off = 1'b0;
    int            mismatches = 0;
    int            tests_sent = 0;
    int            hits_seen = 0;
    int            results_seen = 0;
    int            cycles = 0;

    function automatic longint sx(input logic [CB-1:0] v);
        return longint'($signed(v));
    endfunction

    // closest point on the segment, then inclusive box compare
    function automatic bit hit_of(input logic [DW-1:0] d);
        longint s[3], e[3], c[3], v[3], p[3];
        longint c1, c2, hw, ab, bl, f;
        logic [127:0] q;
        c1 = 0;
        c2 = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = sx(d[i*CB +: CB]);
            e[i] = sx(d[(3+i)*CB +: CB]);
            c[i] = sx(d[(6+i)*CB +: CB]);
            v[i] = e[i] - s[i];
            c1 += (c[i] - s[i]) * v[i];
            c2 += v[i] * v[i];
        end
        hw = longint'(d[9*CB +: EXT_BITS]);
        ab = longint'(d[9*CB+EXT_BITS +: EXT_BITS]);
        bl = longint'(d[9*CB+2*EXT_BITS +: EXT_BITS]);
        if (c1 <= 0) begin
            for (int i = 0; i < 3; i++) p[i] = s[i];
        end else if (c2 <= c1) begin
            for (int i = 0; i < 3; i++) p[i] = e[i];
        end else begin
            q = ({64'd0, c1} << RB) / {64'd0, c2};
            f = longint'(q[RB:0]);
            for (int i = 0; i < 3; i++) p[i] = s[i] + ((v[i] * f) >>> RB);
        end
        return p[0] <= c[0] + hw && p[0] >= c[0] - hw
            && p[1] <= c[1] + hw && p[1] >= c[1] - hw
            && p[2] <= c[2] + ab && p[2] >= c[2] - bl;
    endfunction

    function automatic logic [DW-1:0] pack_test(input longint s[3], input longint e[3],
                                                input longint c[3], input int hw,
                                                input int ab, input int bl);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d[i*CB +: CB] = s[i][CB-1:0];
            d[(3+i)*CB +: CB] = e[i][CB-1:0];
            d[(6+i)*CB +: CB] = c[i][CB-1:0];
        end
        d[9*CB +: EXT_BITS] = hw[15:0];
        d[9*CB+EXT_BITS +: EXT_BITS] = ab[15:0];
        d[9*CB+2*EXT_BITS +: EXT_BITS] = bl[15:0];
        return d;
    endfunction

    function automatic longint near(input longint base, input int span);
        longint r;
        r = base + longint'($urandom_range(2*span)) - span;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r;
    endfunction

    // mostly segments passing close to the entity, some raw noise
    function automatic logic [DW-1:0] rand_test();
        logic [DW-1:0] d;
        longint s[3], e[3], c[3];
        int span, ext;
        int kind;
        kind = $urandom_range(9);
        if (kind < 2) begin
            for (int i = 0; i < DW/8; i++) d[i*8 +: 8] = 8'($urandom());
            return d;
        end
        span = (kind < 5) ? 4096 : 65536;
        ext = (kind < 5) ? 2048 : 65535;
        for (int i = 0; i < 3; i++) begin
            c[i] = longint'($signed($urandom_range(32'hffffff) - 32'h800000));
            s[i] = near(c[i], span);
            e[i] = (kind == 9) ? s[i] : near(c[i], span);
        end
        return pack_test(s, e, c, $urandom_range(ext), $urandom_range(ext),
                         $urandom_range(ext));
    endfunction

    task automatic load_directed();
        longint s[3], e[3], c[3];
        longint lo, hi;
        lo = -8388608;
        hi = 8388607;
        s = '{lo, lo, lo}; e = '{hi, hi, hi}; c = '{0, 0, 0};
        pending_tests.push_back(pack_test(s, e, c, 0, 0, 0));
        pending_tests.push_back(pack_test(s, e, c, 65535, 65535, 65535));
        s = '{hi, hi, hi}; e = '{lo, lo, lo};
        pending_tests.push_back(pack_test(s, e, c, 65535, 65535, 65535));
        c = '{hi, hi, hi};
        pending_tests.push_back(pack_test(s, e, c, 0, 0, 0));
        c = '{lo, lo, lo};
        pending_tests.push_back(pack_test(s, e, c, 0, 0, 0));
        // degenerate segment, inside and outside
        s = '{100, 200, 300}; e = s; c = '{100, 200, 300};
        pending_tests.push_back(pack_test(s, e, c, 0, 0, 0));
        c = '{101, 200, 300};
        pending_tests.push_back(pack_test(s, e, c, 0, 0, 0));
        // projection behind the start, past the end, and interior
        s = '{0, 0, 0}; e = '{1000, 0, 0}; c = '{-50, 0, 0};
        pending_tests.push_back(pack_test(s, e, c, 49, 10, 10));
        pending_tests.push_back(pack_test(s, e, c, 50, 10, 10));
        c = '{1200, 0, 0};
        pending_tests.push_back(pack_test(s, e, c, 200, 0, 0));
        pending_tests.push_back(pack_test(s, e, c, 199, 0, 0));
        c = '{500, 300, 0};
        pending_tests.push_back(pack_test(s, e, c, 300, 0, 0));
        pending_tests.push_back(pack_test(s, e, c, 299, 0, 0));
        // vertical extents, boundaries exact
        s = '{0, 0, -500}; e = '{0, 0, -500}; c = '{0, 0, 0};
        pending_tests.push_back(pack_test(s, e, c, 0, 0, 500));
        pending_tests.push_back(pack_test(s, e, c, 0, 65535, 499));
        s = '{0, 0, 500}; e = s;
        pending_tests.push_back(pack_test(s, e, c, 0, 500, 0));
        pending_tests.push_back(pack_test(s, e, c, 0, 499, 65535));
        // negative deltas, rounding toward minus infinity
        s = '{7, -3, 5}; e = '{-1000, -999, -7}; c = '{-333, -444, 1};
        pending_tests.push_back(pack_test(s, e, c, 200, 10, 10));
        pending_tests.push_back('1);
        pending_tests.push_back('0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                hits_due.push_back(hit_of(i_s_axis_tdata));
                tests_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_tests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tdata <= pending_tests.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (hits_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %h", o_m_axis_tdata);
            end else begin
                automatic logic hit = hits_due.pop_front();
                hits_seen += hit;
                if (o_m_axis_tdata !== {7'd0, hit}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: expected %0d, got %h", hit, o_m_axis_tdata);
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (phase == 1);
        repeat (5) @(posedge i_clk);
        hold_off = 1'b1;
        for (int n = 0; n < 300; n++) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout with %0d results outstanding", hits_due.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int send_pct[4];
        int stall_pct[4];
        send_pct = '{0, 84, 0, 23};
        stall_pct = '{0, 0, 84, 23};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_directed();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            phase = ph + 1;
            repeat (235) pending_tests.push_back(rand_test());
            do @(posedge i_clk);
            while (!(pending_tests.size() == 0 && !i_s_axis_tvalid && hits_due.size() == 0));
        end
        repeat (40) @(posedge i_clk);
        $display("tb: %0d tests over four idle/stall mixes, %0d results, %0d hits",
                 tests_sent, results_seen, hits_seen);
        $display("tb: %0d mismatches", mismatches);
        if (mismatches == 0 && hits_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== segment_box_hit_test.f =====
hw/rtl/sbh_pkg.sv
hw/rtl/sbh_dot.sv
hw/rtl/sbh_div.sv
hw/rtl/sbh_point.sv
hw/rtl/segment_box_hit_test.sv
hw/rtl/sbh_checker.sv
test/tb.sv
